// File: hdl/json_string_unescape_utf8_defines.svh
// Assertion macros shared by the checkers of the JSON string unescaper.
`ifndef JSON_STRING_UNESCAPE_UTF8_DEFINES_SVH
`define JSON_STRING_UNESCAPE_UTF8_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define JSU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("json unescape check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define JSU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("json unescape check failed");

`endif

// File: hdl/jsu_pkg.sv
// Package of types, constants and helper functions for the JSON string unescaper.
package jsu_pkg;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Byte codes
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_LOWER_B   = 8'h62;
    localparam logic [7:0] CH_LOWER_F   = 8'h66;
    localparam logic [7:0] CH_LOWER_N   = 8'h6E;
    localparam logic [7:0] CH_LOWER_R   = 8'h72;
    localparam logic [7:0] CH_LOWER_T   = 8'h74;
    localparam logic [7:0] CH_LOWER_U   = 8'h75;
    localparam logic [7:0] CH_BS        = 8'h08;
    localparam logic [7:0] CH_FF        = 8'h0C;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_TAB       = 8'h09;

    // UTF-8 encoding
    localparam logic [15:0] CP_TWO_BYTE_MIN   = 16'h0080;
    localparam logic [15:0] CP_THREE_BYTE_MIN = 16'h0800;
    localparam logic [7:0]  UTF8_LEAD2        = 8'hC0;
    localparam logic [7:0]  UTF8_LEAD3        = 8'hE0;
    localparam logic [7:0]  UTF8_CONT         = 8'h80;
    localparam logic [7:0]  UTF8_MASK6        = 8'h3F;
    localparam logic [7:0]  UTF8_MASK5        = 8'h1F;
    localparam logic [7:0]  UTF8_MASK4        = 8'h0F;

    localparam logic [1:0] HEX_LAST_DIGIT = 2'd3;

    typedef struct packed {
        logic [7:0] body_byte;
        logic       is_last;
    } body_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       end_of_string;
        logic       status;
    } text_item_t;

    typedef enum logic [4:0] {
        MODE_NORMAL   = 5'b00001,
        MODE_ESCAPE   = 5'b00010,
        MODE_HEX      = 5'b00100,
        MODE_DONE_OK  = 5'b01000,
        MODE_DONE_ERR = 5'b10000
    } mode_t;

    // Work for the back part: up to three bytes, plus the end marker
    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      num_bytes;
        logic            last;
        logic            status;
    } job_t;

    typedef struct packed {
        logic valid;
        job_t job;
    } push_t;

    typedef struct packed {
        logic full;
    } qstat_t;

    typedef struct packed {
        logic valid;
        job_t job;
    } head_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } hex_t;

    typedef struct packed {
        logic       ok;
        logic [7:0] value;
    } esc_t;

    typedef struct packed {
        logic [1:0]      num_bytes;
        logic [2:0][7:0] bytes;
    } utf8_t;

    function automatic hex_t hex_value(input logic [7:0] c);
        hex_t r;
        r.ok    = 1'b1;
        r.value = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r.value = 4'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r.value = 4'(c - 8'h61 + 8'd10);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r.value = 4'(c - 8'h41 + 8'd10);
        end else begin
            r.ok = 1'b0;
        end
        return r;
    endfunction

    function automatic esc_t escape_byte(input logic [7:0] c);
        esc_t r;
        r.ok    = 1'b1;
        r.value = 8'd0;
        case (c)
            CH_QUOTE:     r.value = CH_QUOTE;
            CH_SLASH:     r.value = CH_SLASH;
            CH_BACKSLASH: r.value = CH_BACKSLASH;
            CH_LOWER_B:   r.value = CH_BS;
            CH_LOWER_F:   r.value = CH_FF;
            CH_LOWER_N:   r.value = CH_LF;
            CH_LOWER_R:   r.value = CH_CR;
            CH_LOWER_T:   r.value = CH_TAB;
            default:      r.ok    = 1'b0;
        endcase
        return r;
    endfunction

    function automatic utf8_t utf8_encode(input logic [15:0] cp);
        utf8_t r;
        r.bytes = '0;
        if (cp < CP_TWO_BYTE_MIN) begin
            r.num_bytes = 2'd1;
            r.bytes[0]  = cp[7:0];
        end else if (cp < CP_THREE_BYTE_MIN) begin
            r.num_bytes = 2'd2;
            r.bytes[0]  = UTF8_LEAD2 | (cp[13:6] & UTF8_MASK5);
            r.bytes[1]  = UTF8_CONT | (cp[7:0] & UTF8_MASK6);
        end else begin
            r.num_bytes = 2'd3;
            r.bytes[0]  = UTF8_LEAD3 | ({4'd0, cp[15:12]} & UTF8_MASK4);
            r.bytes[1]  = UTF8_CONT | (cp[13:6] & UTF8_MASK6);
            r.bytes[2]  = UTF8_CONT | (cp[7:0] & UTF8_MASK6);
        end
        return r;
    endfunction

endpackage

// File: hdl/json_string_unescape_utf8.sv
// Top level of the JSON string unescaper with UTF-8 output.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+------------------------------------------------
//  body     | body_valid / body_ready | body_item: body_byte, is_last
//  text     | text_valid / text_ready | text_item: out_byte, has_byte, end_of_string,
//           |                         |            status
//
//  One body byte is taken per cycle while the four-entry work queue has room.
//  Each byte yields zero to three result transfers, given out one per cycle by the
//  back part while text_ready is high; a \u escape expands to at most three bytes
//  after six input bytes. Results pass the work queue and then the output register.
//  rst_n clears the decoder mode, queue pointers and output valid at once.
//  A stall on text fills the queue; body_ready drops only when it is full.
module json_string_unescape_utf8 (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                body_valid,
    output logic                body_ready,
    input  jsu_pkg::body_item_t body_item,
    output logic                text_valid,
    input  logic                text_ready,
    output jsu_pkg::text_item_t text_item
);
    import jsu_pkg::*;

    push_t  push;
    qstat_t qstat;
    head_t  head;
    logic   pop;

    // Decode escapes and hex groups; push one job per byte that yields output or ends the body
    jsu_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .body_valid (body_valid),
        .body_ready (body_ready),
        .body_item  (body_item),
        .qstat      (qstat),
        .push       (push)
    );

    // Hold jobs so the decoder keeps going while the output side stalls
    jsu_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .qstat (qstat),
        .head  (head),
        .pop   (pop)
    );

    // Serialize each job into transfers and place the end marker
    jsu_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .pop        (pop),
        .text_valid (text_valid),
        .text_ready (text_ready),
        .text_item  (text_item)
    );

endmodule

// File: hdl/jsu_front.sv
// Front part: accepts body bytes, runs the escape decoder, and queues output work.
module jsu_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               body_valid,
    output logic               body_ready,
    input  jsu_pkg::body_item_t body_item,
    input  jsu_pkg::qstat_t    qstat,
    output jsu_pkg::push_t     push
);
    import jsu_pkg::*;

    mode_t       mode_reg, mode_next;
    logic [15:0] acc_reg, acc_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        accept;
    hex_t        hv;
    esc_t        ev;
    utf8_t       uv;
    job_t        job;
    logic        status;

    assign body_ready = !qstat.full;
    assign accept     = body_valid && body_ready;

    always_comb
    begin
        mode_next     = mode_reg;
        acc_next      = acc_reg;
        cnt_next      = cnt_reg;
        job.bytes     = '0;
        job.num_bytes = 2'd0;
        hv            = hex_value(body_item.body_byte);
        ev            = escape_byte(body_item.body_byte);
        uv            = utf8_encode({acc_reg[11:0], hv.value});

        unique case (mode_reg) inside
            MODE_DONE_OK, MODE_DONE_ERR:
            begin
                // drop everything until the last byte
            end
            MODE_ESCAPE:
            begin
                if (body_item.body_byte == CH_LOWER_U) begin
                    mode_next = MODE_HEX;
                    acc_next  = '0;
                    cnt_next  = '0;
                end else if (ev.ok) begin
                    job.bytes[0]  = ev.value;
                    job.num_bytes = 2'd1;
                    mode_next     = MODE_NORMAL;
                end else begin
                    mode_next = MODE_DONE_ERR;
                end
            end
            MODE_HEX:
            begin
                if (!hv.ok) begin
                    mode_next = MODE_DONE_ERR;
                end else begin
                    acc_next = {acc_reg[11:0], hv.value};
                    if (cnt_reg == HEX_LAST_DIGIT) begin
                        job.bytes     = uv.bytes;
                        job.num_bytes = uv.num_bytes;
                        cnt_next      = '0;
                        mode_next     = MODE_NORMAL;
                    end else begin
                        cnt_next = cnt_reg + 2'd1;
                    end
                end
            end
            default:
            begin
                mode_next = MODE_NORMAL;
                if (body_item.body_byte == CH_QUOTE) begin
                    mode_next = MODE_DONE_OK;
                end else if (body_item.body_byte == CH_BACKSLASH) begin
                    mode_next = MODE_ESCAPE;
                end else begin
                    job.bytes[0]  = body_item.body_byte;
                    job.num_bytes = 2'd1;
                end
            end
        endcase

        // an escape still open at the end counts as malformed
        status = (mode_next == MODE_DONE_ERR) || (mode_next == MODE_ESCAPE) ||
                 (mode_next == MODE_HEX);
        job.last   = body_item.is_last;
        job.status = status;

        if (body_item.is_last) begin
            mode_next = MODE_NORMAL;
            acc_next  = '0;
            cnt_next  = '0;
        end

        push.valid = accept && ((job.num_bytes != 2'd0) || body_item.is_last);
        push.job   = job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg <= MODE_NORMAL;
            acc_reg  <= '0;
            cnt_reg  <= '0;
        end else if (accept) begin
            mode_reg <= mode_next;
            acc_reg  <= acc_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

// File: hdl/jsu_queue.sv
// Short work queue between the front and back parts.
module jsu_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  jsu_pkg::push_t  push,
    output jsu_pkg::qstat_t qstat,
    output jsu_pkg::head_t  head,
    input  logic            pop
);
    import jsu_pkg::*;

    job_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign qstat.full = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.job   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push.valid ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push.valid) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid) begin
            entry_reg[wr_ptr_reg] <= push.job;
        end
    end

endmodule

// File: hdl/jsu_back.sv
// Back part: expands queued work into result transfers through an output register.
module jsu_back (
    input  logic                clk,
    input  logic                rst_n,
    input  jsu_pkg::head_t      head,
    output logic                pop,
    output logic                text_valid,
    input  logic                text_ready,
    output jsu_pkg::text_item_t text_item
);
    import jsu_pkg::*;

    logic       valid_reg;
    text_item_t item_reg, item_next;
    logic [1:0] idx_reg, idx_next;
    logic [1:0] final_idx;
    logic       load;
    logic       is_final;

    assign text_valid = valid_reg;
    assign text_item  = item_reg;

    always_comb
    begin
        final_idx = (head.job.num_bytes == 2'd0) ? 2'd0 : head.job.num_bytes - 2'd1;
        is_final  = (idx_reg == final_idx);
        load      = head.valid && (!valid_reg || text_ready);
        pop       = load && is_final;
        idx_next  = load ? (is_final ? 2'd0 : idx_reg + 2'd1) : idx_reg;

        case (idx_reg)
            2'd1:    item_next.out_byte = head.job.bytes[1];
            2'd2:    item_next.out_byte = head.job.bytes[2];
            default: item_next.out_byte = head.job.bytes[0];
        endcase
        item_next.has_byte      = (head.job.num_bytes != 2'd0);
        item_next.end_of_string = head.job.last && is_final;
        item_next.status        = head.job.status && head.job.last && is_final;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end else begin
            idx_reg <= idx_next;
            if (load) begin
                valid_reg <= 1'b1;
            end else if (text_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            item_reg <= item_next;
        end
    end

endmodule

// File: hdl/jsu_checker.sv
// Port-level checker for the JSON string unescaper and its bind statement.
`include "json_string_unescape_utf8_defines.svh"

module jsu_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                body_valid,
    input logic                body_ready,
    input jsu_pkg::body_item_t body_item,
    input logic                text_valid,
    input logic                text_ready,
    input jsu_pkg::text_item_t text_item
);
    import jsu_pkg::*;

    logic body_xfer;
    logic text_stall;
    logic text_bare;
    logic text_err;
    logic end_zero;
    logic end_bare;

    assign body_xfer  = body_valid && body_ready && body_item.is_last;
    assign text_stall = text_valid && !text_ready;
    assign text_bare  = text_valid && !text_item.has_byte;
    assign text_err   = text_valid && text_item.status;
    assign end_zero   = text_item.end_of_string && (text_item.out_byte == 8'd0);
    assign end_bare   = text_item.end_of_string && !text_item.has_byte;

    // a stalled result holds
    `JSU_ASSERT_NEXT(a_text_hold, clk, rst_n, text_stall, text_valid && $stable(text_item))
    // a result without a byte is always the end marker, with a zero byte
    `JSU_ASSERT_NOW(a_empty_is_end, clk, rst_n, text_bare, end_zero)
    // a failure status comes only on a bare end marker
    `JSU_ASSERT_NOW(a_err_bare_end, clk, rst_n, text_err, end_bare)
    // the last body byte always leaves work, which makes an idle output go valid
    `JSU_ASSERT_NEXT(a_last_drains, clk, rst_n, body_xfer && !text_valid, ##1 text_valid)

endmodule

bind json_string_unescape_utf8 jsu_checker u_jsu_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .body_valid (body_valid),
    .body_ready (body_ready),
    .body_item  (body_item),
    .text_valid (text_valid),
    .text_ready (text_ready),
    .text_item  (text_item)
);

// File: bench/unescape_scoreboard_pkg.sv
// Scoreboard class that predicts and checks the decoded text of the JSON string unescaper.
package unescape_scoreboard_pkg;

    import jsu_pkg::*;

    class unescape_scoreboard;

        // Decoder state as seen from outside
        mode_t       scan_mode;
        logic [15:0] code_point;
        logic [1:0]  digits_seen;

        text_item_t  expected_text[$];
        int unsigned mismatches;

        function new();
            restart();
            mismatches = 0;
        endfunction

        function void restart();
            scan_mode   = MODE_NORMAL;
            code_point  = '0;
            digits_seen = '0;
        endfunction

        // Advance the decoder by one accepted body byte and queue its text transfers.
        function void note_byte(input body_item_t item);
            logic [7:0] c;
            logic [7:0] decoded[$];
            logic [3:0] nibble;
            logic       is_hex;
            logic       broken;
            text_item_t t;

            c      = item.body_byte;
            is_hex = 1'b1;
            nibble = '0;
            if (c >= "0" && c <= "9")
                nibble = 4'(c - "0");
            else if (c >= "a" && c <= "f")
                nibble = 4'(c - "a" + 8'd10);
            else if (c >= "A" && c <= "F")
                nibble = 4'(c - "A" + 8'd10);
            else
                is_hex = 1'b0;

            case (scan_mode)
                MODE_DONE_OK, MODE_DONE_ERR: ;
                MODE_ESCAPE:
                begin
                    scan_mode = MODE_NORMAL;
                    case (c)
                        CH_LOWER_U:
                        begin
                            scan_mode   = MODE_HEX;
                            code_point  = '0;
                            digits_seen = '0;
                        end
                        CH_QUOTE, CH_SLASH, CH_BACKSLASH: decoded.push_back(c);
                        CH_LOWER_B: decoded.push_back(CH_BS);
                        CH_LOWER_F: decoded.push_back(CH_FF);
                        CH_LOWER_N: decoded.push_back(CH_LF);
                        CH_LOWER_R: decoded.push_back(CH_CR);
                        CH_LOWER_T: decoded.push_back(CH_TAB);
                        default:    scan_mode = MODE_DONE_ERR;
                    endcase
                end
                MODE_HEX:
                begin
                    if (!is_hex)
                    begin
                        scan_mode = MODE_DONE_ERR;
                    end
                    else
                    begin
                        code_point = {code_point[11:0], nibble};
                        if (digits_seen == 2'd3)
                        begin
                            scan_mode   = MODE_NORMAL;
                            digits_seen = '0;
                            if (code_point < 16'h0080)
                            begin
                                decoded.push_back(code_point[7:0]);
                            end
                            else if (code_point < 16'h0800)
                            begin
                                decoded.push_back({3'b110, code_point[10:6]});
                                decoded.push_back({2'b10, code_point[5:0]});
                            end
                            else
                            begin
                                decoded.push_back({4'b1110, code_point[15:12]});
                                decoded.push_back({2'b10, code_point[11:6]});
                                decoded.push_back({2'b10, code_point[5:0]});
                            end
                        end
                        else
                        begin
                            digits_seen = digits_seen + 2'd1;
                        end
                    end
                end
                default:
                begin
                    if (c == CH_QUOTE)
                        scan_mode = MODE_DONE_OK;
                    else if (c == CH_BACKSLASH)
                        scan_mode = MODE_ESCAPE;
                    else
                        decoded.push_back(c);
                end
            endcase

            foreach (decoded[i])
            begin
                t = '{out_byte: decoded[i], has_byte: 1'b1, end_of_string: 1'b0, status: 1'b0};
                expected_text.push_back(t);
            end

            if (item.is_last)
            begin
                broken = scan_mode inside {MODE_DONE_ERR, MODE_ESCAPE, MODE_HEX};
                if (decoded.size() > 0 && !broken)
                begin
                    // end marker rides on the last decoded byte
                    t = expected_text.pop_back();
                    t.end_of_string = 1'b1;
                    expected_text.push_back(t);
                end
                else
                begin
                    t = '{out_byte: 8'd0, has_byte: 1'b0, end_of_string: 1'b1, status: broken};
                    expected_text.push_back(t);
                end
                restart();
            end
        endfunction

        // Compare one accepted text transfer with the oldest expectation.
        function void check_text(input text_item_t got);
            text_item_t want;
            if (expected_text.size() == 0)
            begin
                $error("text transfer with nothing expected: out_byte %h has_byte %b eos %b status %b",
                       got.out_byte, got.has_byte, got.end_of_string, got.status);
                mismatches++;
                return;
            end
            want = expected_text.pop_front();
            if (got.out_byte !== want.out_byte)
            begin
                $error("out_byte: expected %h, got %h", want.out_byte, got.out_byte);
                mismatches++;
            end
            if (got.has_byte !== want.has_byte)
            begin
                $error("has_byte: expected %b, got %b", want.has_byte, got.has_byte);
                mismatches++;
            end
            if (got.end_of_string !== want.end_of_string)
            begin
                $error("end_of_string: expected %b, got %b", want.end_of_string, got.end_of_string);
                mismatches++;
            end
            if (got.status !== want.status)
            begin
                $error("status: expected %b, got %b", want.status, got.status);
                mismatches++;
            end
        endfunction

    endclass

endpackage

// File: bench/json_string_unescape_utf8_test.sv
// Testbench top for the JSON string unescaper: directed and random bodies, checked per transfer.
module json_string_unescape_utf8_test;

    import jsu_pkg::*;
    import unescape_scoreboard_pkg::*;

    // Random bytes that reach the decoder, not counting bytes it ignores
    localparam int RANDOM_BYTES    = 250;
    // Worst case is far below this: ~280 bytes, 3 transfers each, random gaps on both sides
    localparam int CYCLE_LIMIT     = 200000;
    // Long receiver stall that lets the four-entry work queue fill up
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int HOLD_OFF_AFTER  = 40;
    // Leave some margin for stray transfers after the expected ones
    localparam int DRAIN_CYCLES    = 10;

    typedef enum int {
        FAULT_QUOTE,
        FAULT_LETTER,
        FAULT_DIGIT,
        FAULT_CUT
    } fault_t;

    logic       clk;
    logic       rst_n;
    logic       body_valid;
    logic       body_ready;
    body_item_t body_item;
    logic       text_valid;
    logic       text_ready;
    text_item_t text_item;

    unescape_scoreboard board = new();

    int unsigned bytes_taken = 0;
    int unsigned texts_taken = 0;
    int unsigned cycles      = 0;

    logic [7:0] escape_letters [8];

    json_string_unescape_utf8 dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .body_valid (body_valid),
        .body_ready (body_ready),
        .body_item  (body_item),
        .text_valid (text_valid),
        .text_ready (text_ready),
        .text_item  (text_item)
    );

    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Sample both channels at the rising edge; a transfer happens when valid and ready are high.
    // Note the input before checking the output: a result never belongs to a byte of the same edge.
    always @(posedge clk)
    begin
        if (rst_n && body_valid && body_ready)
        begin
            board.note_byte(body_item);
            bytes_taken++;
        end
        if (rst_n && text_valid && text_ready)
        begin
            board.check_text(text_item);
            texts_taken++;
        end
    end

    // Stop a hung run.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("json_string_unescape_utf8_test NOT OK");
            $finish;
        end
    end

    // Pick a hex digit for a nibble, with letters in either case.
    function automatic logic [7:0] hex_char(input logic [3:0] n);
        logic [7:0] base;
        if (n < 4'd10)
            return "0" + 8'(n);
        base = $urandom_range(0, 1) ? "a" : "A";
        return base + 8'(n) - 8'd10;
    endfunction

    // Offer a body one byte at a time. Enter and leave at a falling edge.
    // Keep valid high across back-to-back bytes; drop it only for a gap.
    task automatic send_body(input logic [7:0] bytes[$]);
        int          gap;
        int unsigned goal;
        foreach (bytes[i])
        begin
            // every fourth stretch of 32 bytes runs with no gaps at all
            gap = ((bytes_taken / 32) % 4 == 3) ? 0 : $urandom_range(0, 6);
            if (gap > 0)
            begin
                body_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            body_valid <= 1'b1;
            body_item  <= '{body_byte: bytes[i], is_last: (i == bytes.size() - 1)};
            goal = bytes_taken + 1;
            wait (bytes_taken == goal);
            @(negedge clk);
        end
    endtask

    task automatic send_string(input string s);
        logic [7:0] bytes[$];
        int         i;
        for (i = 0; i < s.len(); i++)
            bytes.push_back(s[i]);
        send_body(bytes);
    endtask

    // Receiver: draw a stall per transfer, hold off once for a long stretch.
    initial
    begin : text_sink
        int          stall;
        int unsigned goal;
        bit          held_off;
        held_off = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (!held_off && texts_taken >= HOLD_OFF_AFTER)
            begin
                // sender keeps going meanwhile, so the block fills and stalls its input
                held_off = 1'b1;
                stall    = HOLD_OFF_CYCLES;
            end
            else
            begin
                stall = ((texts_taken / 32) % 4 == 1) ? 0 : $urandom_range(0, 6);
            end
            if (stall > 0)
            begin
                text_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            text_ready <= 1'b1;
            goal = texts_taken + 1;
            wait (texts_taken == goal);
            @(negedge clk);
        end
    end

    initial
    begin : stimulus
        logic [7:0]  body[$];
        logic [7:0]  b;
        logic [15:0] cp;
        int unsigned random_bytes;
        int          tokens;
        int          pick;
        int          width;
        bit          broken;
        fault_t      fault;

        rst_n      = 1'b0;
        body_valid = 1'b0;
        body_item  = '0;
        text_ready = 1'b0;
        escape_letters = '{CH_QUOTE, CH_SLASH, CH_BACKSLASH, CH_LOWER_B,
                           CH_LOWER_F, CH_LOWER_N, CH_LOWER_R, CH_LOWER_T};

        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed bodies.
        // Extremes of the byte; end marker rides on the plain byte.
        body = '{8'h00, 8'hFF};
        send_body(body);
        // Two-byte sequence from mixed-case hex, then a simple escape as the last byte.
        send_string("\\u07Ff\\\\");
        // Largest code point, three bytes; end rides on the third.
        send_string("\\uFFFF");
        // Bare quote ends with success; the trailing byte is ignored.
        send_string("\"x");
        // Unknown escape letter: error, rest ignored.
        send_string("\\qz");
        // Bad hex digit in the middle of a group.
        send_string("\\u1Ga");
        // Escape cut off by the end of the body.
        send_string("\\");

        // Random bodies: mostly well-formed tokens, with the odd fault near the end.
        random_bytes = 0;
        while (random_bytes < RANDOM_BYTES)
        begin
            body.delete();
            broken = 1'b0;
            tokens = $urandom_range(1, 8);
            for (int t = 0; t < tokens && !broken; t++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 40)
                begin
                    // plain byte, anything but the two special characters
                    do
                        b = 8'($urandom_range(0, 255));
                    while (b == CH_QUOTE || b == CH_BACKSLASH);
                    body.push_back(b);
                end
                else if (pick < 65)
                begin
                    body.push_back(CH_BACKSLASH);
                    body.push_back(escape_letters[$urandom_range(0, 7)]);
                end
                else if (pick < 90)
                begin
                    // spread code points evenly over one, two and three UTF-8 bytes
                    width = $urandom_range(1, 3);
                    if (width == 1)
                        cp = 16'($urandom_range(0, 16'h007F));
                    else if (width == 2)
                        cp = 16'($urandom_range(16'h0080, 16'h07FF));
                    else
                        cp = 16'($urandom_range(16'h0800, 16'hFFFF));
                    body.push_back(CH_BACKSLASH);
                    body.push_back(CH_LOWER_U);
                    for (int k = 3; k >= 0; k--)
                        body.push_back(hex_char(cp[4*k +: 4]));
                end
                else
                begin
                    broken = 1'b1;
                    fault  = fault_t'($urandom_range(0, 3));
                    case (fault)
                        FAULT_QUOTE:
                        begin
                            body.push_back(CH_QUOTE);
                        end
                        FAULT_LETTER:
                        begin
                            do
                                b = 8'($urandom_range(0, 255));
                            while (b inside {CH_QUOTE, CH_SLASH, CH_BACKSLASH, CH_LOWER_B,
                                             CH_LOWER_F, CH_LOWER_N, CH_LOWER_R, CH_LOWER_T,
                                             CH_LOWER_U});
                            body.push_back(CH_BACKSLASH);
                            body.push_back(b);
                        end
                        FAULT_DIGIT:
                        begin
                            body.push_back(CH_BACKSLASH);
                            body.push_back(CH_LOWER_U);
                            repeat ($urandom_range(0, 3))
                                body.push_back(hex_char(4'($urandom)));
                            do
                                b = 8'($urandom_range(0, 255));
                            while (b inside {["0":"9"], ["a":"f"], ["A":"F"]});
                            body.push_back(b);
                        end
                        default:
                        begin
                            // cut the escape off with the end of the body
                            body.push_back(CH_BACKSLASH);
                            if ($urandom_range(0, 1))
                            begin
                                body.push_back(CH_LOWER_U);
                                repeat ($urandom_range(0, 3))
                                    body.push_back(hex_char(4'($urandom)));
                            end
                        end
                    endcase
                end
            end
            random_bytes += body.size();
            // after a quote or an error, trail a few bytes that the decoder must skip
            if (broken && fault != FAULT_CUT)
                repeat ($urandom_range(0, 2))
                    body.push_back(8'($urandom_range(0, 255)));
            send_body(body);
        end
        body_valid <= 1'b0;

        // Drain, then leave time for anything stray to show up.
        while (board.expected_text.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (board.mismatches == 0)
            $display("json_string_unescape_utf8_test OK");
        else
            $display("json_string_unescape_utf8_test NOT OK");
        $finish;
    end

endmodule
